// File: hdl/assert_macros.svh
// assertion macros used by integer_set_table_unit
// no dependencies; expands to nothing when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// condition must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hdl/ist_pkg.sv
// shared types and constants of the integer set table
// no dependencies
package ist_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ELEM_W       = 32;
    localparam int VAL_W        = 31;
    localparam int POS_W        = 6;
    localparam int COUNT_W      = 7;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_FIND   = 2'd3
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_DUP     = 3'd1,
        ST_NEG     = 3'd2,
        ST_FULL    = 3'd3,
        ST_REMOVED = 3'd4,
        ST_ABSENT  = 3'd5,
        ST_CLEARED = 3'd6,
        ST_FOUND   = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_RES  = 4'b0100,
        S_UPD  = 4'b1000
    } state_t;

    // per-cell control, driven by the sequencer
    typedef struct packed {
        logic compare;
        logic load;
        logic shift;
    } ist_cell_ctl_t;

endpackage

// File: hdl/ist_cmd_if.sv
// command channel: valid/ready with command code and element
// depends on ist_pkg
interface ist_cmd_if import ist_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               command;
    logic signed [ELEM_W-1:0] element;

    modport source (output valid, output command, output element, input ready);
    modport sink (input valid, input command, input element, output ready);
endinterface

// File: hdl/ist_rsp_if.sv
// response channel: valid/ready with status, position and count
// depends on ist_pkg
interface ist_rsp_if import ist_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;

    modport source (output valid, output status, output position, output count, input ready);
    modport sink (input valid, input status, input position, input count, output ready);
endinterface

// File: hdl/ist_cell.sv
// one table slot: stored value, compare to key, load key, shift from neighbor
// depends on ist_pkg
module ist_cell import ist_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ist_cell_ctl_t     ctl,
    input  logic [VAL_W-1:0]  key,
    input  logic [VAL_W-1:0]  nb_entry,
    input  logic              occupied,
    output logic [VAL_W-1:0]  entry,
    output logic              match
);

    logic [VAL_W-1:0] entry_reg;
    logic             match_reg;
    logic             match_next;

    assign match_next = ctl.compare & occupied & (entry_reg == key);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            entry_reg <= key;
        end
        else if (ctl.shift)
        begin
            entry_reg <= nb_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

// File: hdl/integer_set_table_unit.sv
// integer set table: insertion-ordered set of non-negative values in a row of cells
// depends on ist_pkg, ist_cmd_if, ist_rsp_if, ist_cell, assert_macros.svh
// each command word runs through the compare, resolve and update steps
// update stalls while a response word waits; the next command enters as it completes
// reset: count cleared, no response pending; stored values are left as they are
`include "assert_macros.svh"
module integer_set_table_unit import ist_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    ist_cmd_if.sink    cmd,
    ist_rsp_if.source  rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // sequencer state
    state_t                state_reg, state_next;
    cmd_code_t             code_reg;
    logic [ELEM_W-1:0]     elem_reg;
    logic [CNT_W-1:0]      count_reg, count_next;

    // resolved search result
    logic                  hit_reg;
    logic [IDX_W-1:0]      pos_reg;
    logic                  hit_next;
    logic [IDX_W-1:0]      pos_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    status_t               status_reg, status_next;
    logic [POS_W-1:0]      position_reg, position_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;

    // cell row
    logic [VAL_W-1:0]      key;
    logic                  key_neg;
    logic [CAPACITY-1:0]   match_vec;
    logic [VAL_W-1:0]      entry_vec [CAPACITY];
    ist_cell_ctl_t         cell_ctl  [CAPACITY];

    logic                  upd_fire;
    logic                  do_load;
    logic                  do_shift;
    logic                  accept;

    assign key     = elem_reg[VAL_W-1:0];
    assign key_neg = elem_reg[ELEM_W-1];

    // update step completes once the output register can take a word
    assign upd_fire = (state_reg == S_UPD) && (!out_valid_reg || rsp.ready);

    // a new command enters at idle, or right as the previous one retires
    assign cmd.ready = (state_reg == S_IDLE) || upd_fire;
    assign accept    = cmd.valid && cmd.ready;

    // ---------------------------------------------------------------
    // cells: each compares its value, loads on append, or takes its
    // right neighbor's value when a removal closes the gap
    // ---------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [VAL_W-1:0] nb;
            if (gi == CAPACITY - 1)
            begin : g_last
                assign nb = entry_vec[gi];
            end
            else
            begin : g_mid
                assign nb = entry_vec[gi + 1];
            end

            assign cell_ctl[gi].compare = (state_reg == S_CMP) && !key_neg;
            assign cell_ctl[gi].load    = do_load && (count_reg == CNT_W'(gi));
            assign cell_ctl[gi].shift   = do_shift && (IDX_W'(gi) >= pos_reg);

            ist_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (cell_ctl[gi]),
                .key      (key),
                .nb_entry (nb),
                .occupied (CNT_W'(gi) < count_reg),
                .entry    (entry_vec[gi]),
                .match    (match_vec[gi])
            );
        end
    endgenerate

    // values are unique, so at most one cell matches: or-reduce the index
    always_comb
    begin
        pos_next = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_vec[i])
            begin
                pos_next = pos_next | IDX_W'(i);
            end
        end
        hit_next = |match_vec;
    end

    // ---------------------------------------------------------------
    // command decode for the update step
    // ---------------------------------------------------------------
    always_comb
    begin
        do_load     = 1'b0;
        do_shift    = 1'b0;
        count_next  = count_reg;
        status_next = ST_ABSENT;
        case (code_reg)
            CMD_ADD:
            begin
                if (key_neg)
                begin
                    status_next = ST_NEG;
                end
                else if (hit_reg)
                begin
                    status_next = ST_DUP;
                end
                else if (count_reg == CNT_W'(CAPACITY))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_ADDED;
                    do_load     = upd_fire;
                    count_next  = count_reg + 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (hit_reg)
                begin
                    status_next = ST_REMOVED;
                    do_shift    = upd_fire;
                    count_next  = count_reg - 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                status_next = ST_CLEARED;
                count_next  = '0;
            end
            CMD_FIND:
            begin
                if (hit_reg)
                begin
                    status_next = ST_FOUND;
                end
            end
            default:
            begin
                status_next = ST_ABSENT;
            end
        endcase
    end

    // position is only reported for found and removed
    assign position_next = (status_next == ST_FOUND || status_next == ST_REMOVED)
                           ? POS_W'(pos_reg) : '0;

    // ---------------------------------------------------------------
    // sequencer and output register
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_RES;
            end
            S_RES:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (upd_fire)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = COUNT_W'(count_next);
                    state_next     = accept ? S_CMP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (upd_fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg <= cmd_code_t'(cmd.command);
            elem_reg <= cmd.element;
        end
        if (state_reg == S_RES)
        begin
            hit_reg <= hit_next;
            pos_reg <= pos_next;
        end
        if (upd_fire)
        begin
            status_reg    <= status_next;
            position_reg  <= position_next;
        end
        out_count_reg <= out_count_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = status_reg;
    assign rsp.position = position_reg;
    assign rsp.count    = out_count_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // count never runs past the capacity
    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(CAPACITY))
    // stored values are unique, so the search hits at most one cell
    `ASSERT_ALWAYS(a_single_match, $onehot0(match_vec))
    // count only moves when a command retires
    `ASSERT_NEXT(a_count_hold, !upd_fire, $stable(count_reg))
    // a successful add grows the set by exactly one
    `ASSERT_NEXT(a_add_grows, upd_fire && status_next == ST_ADDED,
                 count_reg == $past(count_reg) + 1'b1)

endmodule

// File: verif/ist_table_checker.sv
// integer set table checker: watches the command and response channels,
// predicts every response word and compares it; depends on ist_pkg, ist_cmd_if, ist_rsp_if
`timescale 1ns / 100ps
module ist_table_checker import ist_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    ist_cmd_if   cmd,
    ist_rsp_if   rsp,
    output int   failures,
    output int   pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        status_t            status;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
    } answer_t;

    // predicted contents of the table
    logic [VAL_W-1:0] held_values [CAPACITY];
    int               held_count = 0;

    answer_t answer_q[$];
    int      fail_count = 0;
    int      words_checked = 0;

    // slot of a held value, or -1
    function automatic int find_slot(logic [ELEM_W-1:0] value);
        if (value[ELEM_W-1])
            return -1;
        for (int i = 0; i < held_count; i++)
            if (held_values[i] == value[VAL_W-1:0])
                return i;
        return -1;
    endfunction

    function automatic answer_t apply_command(cmd_code_t code, logic [ELEM_W-1:0] value);
        answer_t a;
        int      slot;
        slot = find_slot(value);
        a.status = ST_ABSENT;
        a.position = '0;
        case (code)
            CMD_ADD:
            begin
                // duplicate check ranks above the full check
                if (value[ELEM_W-1])
                    a.status = ST_NEG;
                else if (slot >= 0)
                    a.status = ST_DUP;
                else if (held_count >= CAPACITY)
                    a.status = ST_FULL;
                else
                begin
                    held_values[held_count] = value[VAL_W-1:0];
                    held_count++;
                    a.status = ST_ADDED;
                end
            end
            CMD_REMOVE:
            begin
                if (slot >= 0)
                begin
                    for (int i = slot; i + 1 < held_count; i++)
                        held_values[i] = held_values[i + 1];
                    held_count--;
                    a.status = ST_REMOVED;
                    a.position = slot[POS_W-1:0];
                end
            end
            CMD_CLEAR:
            begin
                held_count = 0;
                a.status = ST_CLEARED;
            end
            default:
            begin
                if (slot >= 0)
                begin
                    a.status = ST_FOUND;
                    a.position = slot[POS_W-1:0];
                end
            end
        endcase
        a.count = held_count[COUNT_W-1:0];
        return a;
    endfunction

    task automatic log_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            held_count = 0;
            answer_q.delete();
            pending <= 0;
            failures <= fail_count;
        end
        else
        begin
            // a response word always belongs to an older command word
            if (rsp.valid && rsp.ready)
            begin
                if (answer_q.size() == 0)
                    log_failure($sformatf("unexpected response word: status %0d pos %0d count %0d",
                                          rsp.status, rsp.position, rsp.count));
                else
                begin
                    want = answer_q.pop_front();
                    if (rsp.status !== want.status || rsp.position !== want.position ||
                        rsp.count !== want.count)
                        log_failure($sformatf({"response word %0d: expected status %s pos %0d ",
                                               "count %0d, got status %0d pos %0d count %0d"},
                                              words_checked, want.status.name(), want.position,
                                              want.count, rsp.status, rsp.position, rsp.count));
                end
                words_checked++;
            end
            if (cmd.valid && cmd.ready)
                answer_q.push_back(apply_command(cmd_code_t'(cmd.command), cmd.element));
            pending <= answer_q.size();
            failures <= fail_count;
        end
    end

endmodule

// File: verif/tb.sv
// top of the integer set table testbench: clock, reset, command stimulus,
// response back-pressure, watchdog and verdict; depends on ist_pkg, both channel
// interfaces, integer_set_table_unit and ist_table_checker
`timescale 1ns / 100ps
module tb;
    import ist_pkg::*;

    localparam int TABLE_DEPTH  = CAPACITY_DEF;
    localparam int TOTAL_WORDS  = 1600;
    localparam int STALL_LIMIT  = 4000;   // cycles with no word moving on either channel
    localparam int DRAIN_CYCLES = 12;     // extra wait after the checker has no response pending
    localparam int HOLD_AFTER   = 300;    // response words seen before the long hold-off
    localparam int HOLD_CYCLES  = 200;
    localparam int POOL_MAX     = 96;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   failures;
    int   pending;

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    ist_cmd_if cmd_ch ();
    ist_rsp_if rsp_ch ();

    integer_set_table_unit #(.CAPACITY(TABLE_DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    ist_table_checker #(.CAPACITY(TABLE_DEPTH)) table_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_ch),
        .rsp      (rsp_ch),
        .failures (failures),
        .pending  (pending)
    );

    // values that a phase draws from, so adds, finds and removes keep meeting
    logic [ELEM_W-1:0] value_pool [POOL_MAX];
    int                pool_size = 1;
    int                words_sent = 0;

    // mostly small consecutive values, some wide ones, all non-negative
    function automatic void refill_pool(int size);
        pool_size = size;
        for (int i = 0; i < size; i++)
            value_pool[i] = ($urandom_range(0, 3) == 0) ? ($urandom & 32'h7FFF_FFFF) : i;
    endfunction

    function automatic logic [ELEM_W-1:0] pick_element();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return value_pool[$urandom_range(0, pool_size - 1)];
        if (r < 90)
            return $urandom;    // full width, negatives included
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic cmd_code_t pick_command(int clear_pct, int add_pct, int remove_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < clear_pct)
            return CMD_CLEAR;
        if (r < clear_pct + add_pct)
            return CMD_ADD;
        if (r < clear_pct + add_pct + remove_pct)
            return CMD_REMOVE;
        return CMD_FIND;
    endfunction

    // idle cycles before a word: mostly none or short, a few long
    function automatic int pick_gap(bit no_gaps);
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one command word and hold it until the block takes it;
    // valid is only lowered when a gap follows, so it never toggles within one step
    task automatic send_word(cmd_code_t code, logic [ELEM_W-1:0] value, int gap);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= code;
        cmd_ch.element <= value;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // command stimulus and verdict
    initial
    begin
        int                phase_index;
        int                phase_len;
        bit                no_gaps;
        int                clear_pct;
        int                add_pct;
        int                remove_pct;
        logic [ELEM_W-1:0] fill_base;

        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= CMD_ADD;
        cmd_ch.element <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, negatives, duplicates, shifts, clear
        send_word(CMD_FIND,   32'd5,          pick_gap(0));   // lookup in empty table
        send_word(CMD_REMOVE, 32'd5,          pick_gap(0));   // remove from empty table
        send_word(CMD_ADD,    32'h0000_0000,  pick_gap(0));
        send_word(CMD_ADD,    32'h7FFF_FFFF,  pick_gap(0));   // largest legal value
        send_word(CMD_ADD,    32'h8000_0000,  pick_gap(0));   // most negative
        send_word(CMD_ADD,    32'hFFFF_FFFF,  pick_gap(0));   // minus one
        send_word(CMD_ADD,    32'h0000_0000,  pick_gap(0));   // duplicate
        send_word(CMD_ADD,    32'd12345,      pick_gap(0));
        send_word(CMD_ADD,    32'h2AAA_AAAA,  pick_gap(0));
        send_word(CMD_ADD,    32'h5555_5555,  pick_gap(0));
        send_word(CMD_FIND,   32'h7FFF_FFFF,  pick_gap(0));
        send_word(CMD_FIND,   32'hFFFF_FFFF,  pick_gap(0));   // negative lookup
        send_word(CMD_FIND,   32'h7FFF_FFFE,  pick_gap(0));   // missing value
        send_word(CMD_REMOVE, 32'h7FFF_FFFF,  pick_gap(0));   // middle entry, tail shifts down
        send_word(CMD_FIND,   32'h5555_5555,  pick_gap(0));   // position after the shift
        send_word(CMD_REMOVE, 32'hFFFF_FFFB,  pick_gap(0));   // negative remove
        send_word(CMD_REMOVE, 32'h0000_0000,  pick_gap(0));   // head entry
        send_word(CMD_REMOVE, 32'h5555_5555,  pick_gap(0));   // tail entry
        send_word(CMD_REMOVE, 32'h5555_5555,  pick_gap(0));   // already gone
        send_word(CMD_CLEAR,  32'h0000_0000,  pick_gap(0));
        send_word(CMD_FIND,   32'd12345,      pick_gap(0));   // nothing left after clear
        send_word(CMD_CLEAR,  32'hFFFF_FFFF,  pick_gap(0));   // clear an empty table
        send_word(CMD_ADD,    32'd3,          pick_gap(0));

        // fill to capacity, then a duplicate, a fresh value on a full table, a remove and a find
        fill_base = $urandom_range(0, 100000);
        for (int i = 0; i < TABLE_DEPTH + 2; i++)
            send_word(CMD_ADD, fill_base + i, pick_gap(0));
        send_word(CMD_ADD, fill_base + 5, pick_gap(0));
        send_word(CMD_ADD, 32'h7FFF_FFFF, pick_gap(0));
        send_word(CMD_REMOVE, fill_base + 1, pick_gap(0));
        send_word(CMD_FIND, fill_base + TABLE_DEPTH - 1, pick_gap(0));

        // random phases: fill-heavy, growing, and churning mixes
        phase_index = 0;
        while (words_sent < TOTAL_WORDS)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    clear_pct = 0;  add_pct = 85; remove_pct = 5;
                    refill_pool(POOL_MAX);
                end
                1:
                begin
                    clear_pct = 2;  add_pct = 55; remove_pct = 20;
                    refill_pool($urandom_range(4, 48));
                end
                default:
                begin
                    clear_pct = 3;  add_pct = 35; remove_pct = 35;
                    refill_pool($urandom_range(2, 24));
                end
            endcase
            phase_len = $urandom_range(40, 160);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < phase_len; i++)
                send_word(pick_command(clear_pct, add_pct, remove_pct), pick_element(),
                          pick_gap(no_gaps));
            // now and then let the block drain completely before going on
            if (phase_index == 2 || $urandom_range(0, 5) == 0)
            begin
                cmd_ch.valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            phase_index++;
        end

        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // response back-pressure: random stalls, ready-only windows, and one long hold-off
    initial
    begin
        int stall_left = 0;
        int results_seen = 0;
        int cycle_no = 0;
        bit held = 1'b0;

        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (rsp_ch.valid && rsp_ch.ready)
                results_seen++;
            if (!held && results_seen >= HOLD_AFTER)
            begin
                // sender keeps going, so the block backs up and stalls its input
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (cycle_no % 512 < 128)
                rsp_ch.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 70)
                rsp_ch.ready <= 1'b1;
            else
            begin
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                         : $urandom_range(10, 40);
                rsp_ch.ready <= 1'b0;
            end
        end
    end

    // watchdog: too long with no word moving on either channel
    initial
    begin
        int idle_cycles = 0;

        @(posedge rst_n);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/ist_pkg.sv
hdl/ist_cmd_if.sv
hdl/ist_rsp_if.sv
hdl/ist_cell.sv
hdl/integer_set_table_unit.sv
verif/ist_table_checker.sv
verif/tb.sv
